// ----- design/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg: shared types for the point to segment distance block
// Beat structures for both channels, the region codes and default sizes.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Width of each coordinate field in a beat.
    localparam int COORD_FIELD_BITS = 16;
    // Default number of coordinate bits that take part in the arithmetic.
    localparam int COORD_BITS_DEF   = 16;
    // Width of the distance field in a result beat.
    localparam int DIST_FIELD_BITS  = COORD_FIELD_BITS + 1;

    typedef enum logic [1:0] {
        REGION_INTERIOR   = 2'd0,
        REGION_START      = 2'd1,
        REGION_END        = 2'd2,
        REGION_DEGENERATE = 2'd3
    } region_t;

    typedef struct packed {
        logic signed [COORD_FIELD_BITS-1:0] point_x;
        logic signed [COORD_FIELD_BITS-1:0] point_y;
        logic signed [COORD_FIELD_BITS-1:0] point_z;
        logic signed [COORD_FIELD_BITS-1:0] start_x;
        logic signed [COORD_FIELD_BITS-1:0] start_y;
        logic signed [COORD_FIELD_BITS-1:0] start_z;
        logic signed [COORD_FIELD_BITS-1:0] end_x;
        logic signed [COORD_FIELD_BITS-1:0] end_y;
        logic signed [COORD_FIELD_BITS-1:0] end_z;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_FIELD_BITS-1:0] distance;
        region_t                    region;
    } out_beat_t;

endpackage

// ----- design/point_segment_distance_3d.sv -----
// ----------------------------------------------------------------------------
// point_segment_distance_3d: streaming point to line segment distance
// Fully pipelined integer distance from a 3-D point to a segment.
// ----------------------------------------------------------------------------
// Usage. Each input beat on s_valid/s_ready/s_data carries a query point and
// the two endpoints of a segment as signed coordinates. For every input beat
// exactly one result beat leaves on m_valid/m_ready/m_data, in order, holding
// the floor square root of the squared distance and a region code telling
// whether the closest point lies inside the segment, at the start, at the end,
// or whether the segment has zero length (then the distance to the start).
// Only the low COORD_BITS bits of each coordinate field take part; COORD_BITS
// may range from 4 up to the width of the coordinate fields.
// Throughput is one beat per clock while s_ready is high. A beat passes
// through 3*COORD_BITS + 10 registers: four front stages for the
// differences, products, sums and the partial products of n squared, one
// that assembles the numerator, one per quotient bit of the restoring
// divider (2*COORD_BITS + 2 of them), one for the subtraction, one per root
// bit of the square root (COORD_BITS + 1) and the output register.
// A synchronous active-low reset on aresetn empties every stage. When the
// receiver stalls, the result waits in the output register and one further
// result is caught in a skid register; only once that is full does s_ready
// drop and the whole pipeline hold, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module point_segment_distance_3d #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  psd_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output psd_pkg::out_beat_t  m_data
);
    import psd_pkg::*;

    // Differences are one bit wider than a coordinate; products and sums of
    // squares are 2*COORD_BITS+2 bits; the dot product needs a sign bit more.
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int NW = PW + 1;
    localparam int UW = PW;
    localparam int HW = UW / 2;       // half of n, also the root width
    localparam int NB = 2 * UW;       // numerator n*n
    localparam int QB = UW;           // quotient bits, since n <= d
    localparam int RM = HW + 2;       // square root remainder width

    // The whole pipeline moves together; it holds only while the skid
    // register is occupied.
    logic en;
    logic skid_valid_reg;
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---------------- stage 1: differences ----------------
    logic                 s1_valid_reg;
    logic signed [DW-1:0] s1_w_reg  [3];
    logic signed [DW-1:0] s1_v_reg  [3];
    logic signed [DW-1:0] s1_we_reg [3];

    logic signed [DW-1:0] in_p [3];
    logic signed [DW-1:0] in_s [3];
    logic signed [DW-1:0] in_e [3];

    always_comb begin
        in_p[0] = DW'($signed(s_data.point_x[COORD_BITS-1:0]));
        in_p[1] = DW'($signed(s_data.point_y[COORD_BITS-1:0]));
        in_p[2] = DW'($signed(s_data.point_z[COORD_BITS-1:0]));
        in_s[0] = DW'($signed(s_data.start_x[COORD_BITS-1:0]));
        in_s[1] = DW'($signed(s_data.start_y[COORD_BITS-1:0]));
        in_s[2] = DW'($signed(s_data.start_z[COORD_BITS-1:0]));
        in_e[0] = DW'($signed(s_data.end_x[COORD_BITS-1:0]));
        in_e[1] = DW'($signed(s_data.end_y[COORD_BITS-1:0]));
        in_e[2] = DW'($signed(s_data.end_z[COORD_BITS-1:0]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_w_reg[i]  <= in_p[i] - in_s[i];
                s1_v_reg[i]  <= in_e[i] - in_s[i];
                s1_we_reg[i] <= in_p[i] - in_e[i];
            end
        end
    end

    // ---------------- stage 2: products ----------------
    logic                 s2_valid_reg;
    logic signed [PW-1:0] s2_wv_reg  [3];
    logic signed [PW-1:0] s2_vv_reg  [3];
    logic signed [PW-1:0] s2_ww_reg  [3];
    logic signed [PW-1:0] s2_wwe_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s2_wv_reg[i]  <= PW'(s1_w_reg[i] * s1_v_reg[i]);
                s2_vv_reg[i]  <= PW'(s1_v_reg[i] * s1_v_reg[i]);
                s2_ww_reg[i]  <= PW'(s1_w_reg[i] * s1_w_reg[i]);
                s2_wwe_reg[i] <= PW'(s1_we_reg[i] * s1_we_reg[i]);
            end
        end
    end

    // ---------------- stage 3: sums ----------------
    logic                 s3_valid_reg;
    logic signed [NW-1:0] s3_n_reg;
    logic        [UW-1:0] s3_d_reg;
    logic        [UW-1:0] s3_ww_reg;
    logic        [UW-1:0] s3_wwe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Squares are never negative, so their sum is taken as unsigned.
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_n_reg   <= NW'(s2_wv_reg[0]) + NW'(s2_wv_reg[1]) + NW'(s2_wv_reg[2]);
            s3_d_reg   <= UW'(s2_vv_reg[0]) + UW'(s2_vv_reg[1]) + UW'(s2_vv_reg[2]);
            s3_ww_reg  <= UW'(s2_ww_reg[0]) + UW'(s2_ww_reg[1]) + UW'(s2_ww_reg[2]);
            s3_wwe_reg <= UW'(s2_wwe_reg[0]) + UW'(s2_wwe_reg[1]) + UW'(s2_wwe_reg[2]);
        end
    end

    // ---------------- stage 4: region and partial products of n*n ----------
    logic              s4_valid_reg;
    region_t           s4_region_reg;
    logic [UW-1:0]     s4_base_reg;
    logic [UW-1:0]     s4_d_reg;
    logic [2*HW-1:0]   s4_pp11_reg;
    logic [2*HW-1:0]   s4_pp10_reg;
    logic [2*HW-1:0]   s4_pp00_reg;

    region_t       region_next;
    logic [UW-1:0] base_next;
    logic [UW-1:0] nmag;

    // On the interior path 0 <= n <= d, so n fits in UW bits; elsewhere the
    // partial products are not used.
    assign nmag = s3_n_reg[UW-1:0];

    always_comb begin
        priority if (s3_d_reg == '0) begin
            region_next = REGION_DEGENERATE;
            base_next   = s3_ww_reg;
        end else if (s3_n_reg[NW-1]) begin
            region_next = REGION_START;
            base_next   = s3_ww_reg;
        end else if (s3_n_reg > $signed({1'b0, s3_d_reg})) begin
            region_next = REGION_END;
            base_next   = s3_wwe_reg;
        end else begin
            region_next = REGION_INTERIOR;
            base_next   = s3_ww_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_region_reg <= region_next;
            s4_base_reg   <= base_next;
            s4_d_reg      <= s3_d_reg;
            s4_pp11_reg   <= nmag[UW-1:HW] * nmag[UW-1:HW];
            s4_pp10_reg   <= nmag[UW-1:HW] * nmag[HW-1:0];
            s4_pp00_reg   <= nmag[HW-1:0] * nmag[HW-1:0];
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    // Entry 0 is loaded with the assembled numerator; since the quotient is
    // below 2^QB, its upper half is already smaller than d.
    logic          div_valid_reg  [QB+1];
    logic [UW-1:0] div_rem_reg    [QB+1];
    logic [QB-1:0] div_num_reg    [QB+1];
    logic [QB-1:0] div_quot_reg   [QB+1];
    logic [UW-1:0] div_d_reg      [QB+1];
    logic [UW-1:0] div_base_reg   [QB+1];
    region_t       div_region_reg [QB+1];

    logic [NB-1:0] numerator;
    assign numerator = {s4_pp11_reg, s4_pp00_reg} + (NB'(s4_pp10_reg) << (HW + 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg[0] <= 1'b0;
        end else if (en) begin
            div_valid_reg[0] <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_rem_reg[0]    <= numerator[NB-1:QB];
            div_num_reg[0]    <= numerator[QB-1:0];
            div_quot_reg[0]   <= '0;
            div_d_reg[0]      <= s4_d_reg;
            div_base_reg[0]   <= s4_base_reg;
            div_region_reg[0] <= s4_region_reg;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [UW:0] trial;
        logic        fits;
        assign trial = {div_rem_reg[k], div_num_reg[k][QB-1]};
        assign fits  = trial >= {1'b0, div_d_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_rem_reg[k+1]    <= fits ? UW'(trial - {1'b0, div_d_reg[k]}) : UW'(trial);
                div_num_reg[k+1]    <= div_num_reg[k] << 1;
                div_quot_reg[k+1]   <= {div_quot_reg[k][QB-2:0], fits};
                div_d_reg[k+1]      <= div_d_reg[k];
                div_base_reg[k+1]   <= div_base_reg[k];
                div_region_reg[k+1] <= div_region_reg[k];
            end
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    // Entry 0 takes the squared distance; interior results subtract the
    // quotient and clamp at zero.
    logic          sq_valid_reg  [HW+1];
    logic [UW-1:0] sq_src_reg    [HW+1];
    logic [RM-1:0] sq_rem_reg    [HW+1];
    logic [HW-1:0] sq_root_reg   [HW+1];
    region_t       sq_region_reg [HW+1];

    logic [UW-1:0] sq_next;
    always_comb begin
        if (div_region_reg[QB] == REGION_INTERIOR) begin
            sq_next = (div_quot_reg[QB] <= div_base_reg[QB]) ?
                      (div_base_reg[QB] - div_quot_reg[QB]) : '0;
        end else begin
            sq_next = div_base_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (en) begin
            sq_valid_reg[0] <= div_valid_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_src_reg[0]    <= sq_next;
            sq_rem_reg[0]    <= '0;
            sq_root_reg[0]   <= '0;
            sq_region_reg[0] <= div_region_reg[QB];
        end
    end

    for (genvar j = 0; j < HW; j++) begin : g_sqrt
        logic [RM-1:0] acc;
        logic [RM-1:0] cand;
        logic          take;
        assign acc  = {sq_rem_reg[j][RM-3:0], sq_src_reg[j][UW-1:UW-2]};
        assign cand = {sq_root_reg[j], 2'b01};
        assign take = acc >= cand;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[j+1] <= sq_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_src_reg[j+1]    <= sq_src_reg[j] << 2;
                sq_rem_reg[j+1]    <= take ? (acc - cand) : acc;
                sq_root_reg[j+1]   <= {sq_root_reg[j][HW-2:0], take};
                sq_region_reg[j+1] <= sq_region_reg[j];
            end
        end
    end

    // ---------------- output register and skid ----------------
    out_beat_t result;
    always_comb begin
        result.distance = DIST_FIELD_BITS'(sq_root_reg[HW]);
        result.region   = sq_region_reg[HW];
    end

    logic      out_valid_reg;
    out_beat_t out_data_reg;
    out_beat_t skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            if (sq_valid_reg[HW]) begin
                if (out_valid_reg && !m_ready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (m_ready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sq_valid_reg[HW]) begin
                if (out_valid_reg && !m_ready) begin
                    skid_data_reg <= result;
                end else begin
                    out_data_reg <= result;
                end
            end
        end else if (m_ready) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- design/psd_checker.sv -----
// ----------------------------------------------------------------------------
// psd_checker: port level checks for the distance block
// Watches the handshakes of both channels and the flow control between them.
// ----------------------------------------------------------------------------
module psd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input psd_pkg::in_beat_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input psd_pkg::out_beat_t  m_data
);
    import psd_pkg::*;

    // Reset leaves no result on offer.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // A waiting input beat stays and keeps its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting input beat changed or vanished");

    // A stalled result beat stays and keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed or vanished");

    // The input side is throttled only while a result is waiting.
    a_throttle: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // Ready falls only after the receiver refused a beat.
    a_fall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input ready dropped without an output stall");

endmodule

bind point_segment_distance_3d psd_checker u_psd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- dv/point_segment_distance_3d_tb.sv -----
// ----------------------------------------------------------------------------
// point_segment_distance_3d_tb: self-checking bench for the distance block
// Directed and random query beats are driven with random gaps, results are
// drained with random stalls and compared field by field against a local
// integer model of the point to segment distance.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_tb;
    import psd_pkg::*;

    localparam int CB         = COORD_BITS_DEF;
    localparam int LATENCY    = 4 * CB + 11;
    localparam int N_RANDOM   = 1600;
    // Longest idle stretch: a full pipeline plus the worst gap or stall, with margin.
    localparam int STALL_LIMIT = 20 * (LATENCY + 20);

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    in_beat_t  pending_queries[$];
    out_beat_t expected_results[$];
    int        n_errors = 0;
    int        idle_cycles = 0;
    bit        stimulus_done = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    point_segment_distance_3d dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Integer floor square root, one root bit per pass.
    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned rem, root, b;
        rem = x;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    // Expected distance and region for one query. The interior case is kept
    // exact by forming n squared at 128 bits before dividing by d.
    function automatic out_beat_t segment_distance(in_beat_t q);
        longint p[3], s[3], e[3];
        longint wv, vv, wev, n;
        longint unsigned d, ww, wwe, sq;
        logic [127:0] nsq, quot;
        out_beat_t r;
        p = '{q.point_x, q.point_y, q.point_z};
        s = '{q.start_x, q.start_y, q.start_z};
        e = '{q.end_x, q.end_y, q.end_z};
        n = 0; d = 0; ww = 0; wwe = 0;
        for (int i = 0; i < 3; i++) begin
            wv  = p[i] - s[i];
            vv  = e[i] - s[i];
            wev = p[i] - e[i];
            n  += wv * vv;
            d  += vv * vv;
            ww += wv * wv;
            wwe += wev * wev;
        end
        if (d == 0) begin
            r.region = REGION_DEGENERATE;
            sq = ww;
        end else if (n < 0) begin
            r.region = REGION_START;
            sq = ww;
        end else if (longint'(unsigned'(n)) > d) begin
            r.region = REGION_END;
            sq = wwe;
        end else begin
            r.region = REGION_INTERIOR;
            nsq  = 128'(n) * 128'(n);
            quot = nsq / 128'(d);
            sq   = (quot <= 128'(ww)) ? ww - quot[63:0] : 64'd0;
        end
        r.distance = DIST_FIELD_BITS'(floor_root(sq));
        return r;
    endfunction

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_beat_t make_query(logic [15:0] px, logic [15:0] py,
                                            logic [15:0] pz, logic [15:0] sx,
                                            logic [15:0] sy, logic [15:0] sz,
                                            logic [15:0] ex, logic [15:0] ey,
                                            logic [15:0] ez);
        in_beat_t q;
        q = '{px, py, pz, sx, sy, sz, ex, ey, ez};
        return q;
    endfunction

    initial begin
        in_beat_t q;
        // Extremes: opposite corners of the coordinate cube.
        pending_queries.push_back(make_query(16'h8000, 16'h8000, 16'h8000,
            16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        pending_queries.push_back(make_query(16'h7fff, 16'h7fff, 16'h7fff,
            16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff));
        pending_queries.push_back(make_query(16'h8000, 16'h7fff, 16'h8000,
            16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff));
        pending_queries.push_back('0);
        pending_queries.push_back('1);
        // Zero-length segment away from the point.
        pending_queries.push_back(make_query(16'd3, 16'd4, 16'd0,
            16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        // Closest to the start, closest to the end, and an interior point.
        pending_queries.push_back(make_query(-16'sd5, 16'd1, 16'd0,
            16'd0, 16'd0, 16'd0, 16'd10, 16'd0, 16'd0));
        pending_queries.push_back(make_query(16'd15, 16'd2, 16'd0,
            16'd0, 16'd0, 16'd0, 16'd10, 16'd0, 16'd0));
        pending_queries.push_back(make_query(16'd4, 16'd3, 16'd7,
            16'd0, 16'd0, 16'd0, 16'd10, 16'd0, 16'd0));
        // Projection landing exactly on the start and exactly on the end.
        pending_queries.push_back(make_query(16'd0, 16'd9, 16'd0,
            16'd0, 16'd0, 16'd0, 16'd10, 16'd0, 16'd0));
        pending_queries.push_back(make_query(16'd10, 16'd9, 16'd0,
            16'd0, 16'd0, 16'd0, 16'd10, 16'd0, 16'd0));
        // Diagonal segment with a non-exact division.
        pending_queries.push_back(make_query(16'd7, -16'sd3, 16'd11,
            -16'sd2, 16'd5, 16'd1, 16'd9, 16'd8, -16'sd6));

        for (int i = 0; i < N_RANDOM; i++) begin
            q = make_query(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                           rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                           rnd_coord());
            case ($urandom_range(0, 9))
                0: begin
                    // Zero-length segment.
                    q.end_x = q.start_x; q.end_y = q.start_y; q.end_z = q.start_z;
                end
                1: begin
                    // Short segment along x between nearby endpoints; the point stays random.
                    q.end_x = q.start_x + 16'($signed($urandom_range(0, 8)) - 4);
                    q.end_y = q.start_y;
                    q.end_z = q.start_z;
                end
                default: ;
            endcase
            pending_queries.push_back(q);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: a beat stays presented until accepted; the gap after it is drawn when it is presented.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(segment_distance(s_data));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_queries.size() > 0) begin
                    s_data   <= pending_queries.pop_front();
                    s_valid  <= 1'b1;
                    // Long runs with no gap as well as gaps of random length.
                    send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
                end else begin
                    s_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks each accepted result beat and drives ready with stalls.
    // A draw of zero keeps ready high so results can drain back to back.
    always @(posedge aclk) begin
        out_beat_t exp_r;
        int        wait_draw;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no query outstanding: distance %0d region %0d",
                           m_data.distance, m_data.region);
                    n_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data.distance !== exp_r.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               exp_r.distance, m_data.distance);
                        n_errors++;
                    end
                    if (m_data.region !== exp_r.region) begin
                        $error("region: expected %0d, actual %0d",
                               exp_r.region, m_data.region);
                        n_errors++;
                    end
                end
                wait_draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
                if (wait_draw == 0) begin
                    recv_gap <= 0;
                    m_ready  <= 1'b1;
                end else begin
                    recv_gap <= wait_draw - 1;
                    m_ready  <= 1'b0;
                end
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog and end of run.
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) break;
            if (stimulus_done && expected_results.size() == 0) break;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
        end else begin
            // Let any stray beat surface before the verdict.
            repeat (LATENCY + 20) @(posedge aclk);
            if (n_errors == 0 && expected_results.size() == 0) begin
                $display("end of test: clean");
            end else begin
                $display("end of test: mismatches");
            end
        end
        $finish;
    end
endmodule
